// ===== rtl/dda_pkg.sv =====
// Shared constants, command type for the DDA line rasteriser.
`default_nettype none

package dda_pkg;

  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 24;
  localparam int MAX_STEPS = 63;
  localparam int FRAC_BITS = 16;

  localparam int CNT_W     = $clog2(MAX_STEPS + 1);
  localparam int NUM_W     = COORD_W + FRAC_BITS;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int INC_W     = FRAC_BITS + 2;
  localparam int ACC_W     = COORD_W + FRAC_BITS + 2;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [INC_W-1:0]   inc_x;
    logic signed [INC_W-1:0]   inc_y;
    logic [CNT_W-1:0]          last_idx;
    logic                      cut;
    logic [COLOR_W-1:0]        color;
  } dda_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dda_if.sv =====
// Valid/ready channel interfaces for line requests and pixels.
`default_nettype none

interface dda_in_if import dda_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [COLOR_W-1:0]        line_color;

  modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface dda_out_if import dda_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pixel_x;
  logic signed [COORD_W-1:0] pixel_y;
  logic [COLOR_W-1:0]        pixel_color;
  logic                      last_pixel;
  logic                      was_truncated;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, was_truncated,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, was_truncated,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/dda_line_rasterizer.sv =====
// A zero-length line skips the divide in the front end.
// The front end holds one line at a time and runs two dividers in parallel; the back end
// emits one pixel per cycle unless stalled, plus a load step per line, up to 64 pixels.
// A two-entry command queue lets the next divide overlap the current burst.
// Reset: synchronous, active low; clears all control state, queue empty, no pixel pending.
`default_nettype none

module dda_line_rasterizer import dda_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dda_in_if.sink     in_line,
  dda_out_if.source  out_pixel
);

  logic     f_valid, f_ready, b_valid, b_ready;
  dda_cmd_t f_cmd, b_cmd;

  dda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_line   (in_line),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  dda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  dda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .out_pixel (out_pixel)
  );

endmodule

`default_nettype wire

// ===== rtl/dda_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module dda_div import dda_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [COORD_W-1:0] den,
  output logic                    done,
  output logic [QUO_W-1:0]        quo
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [COORD_W-1:0]   rem_r;
  logic [QUO_W-1:0]     lo_r;
  logic [COORD_W-1:0]   den_r;

  logic [COORD_W:0]     trial;
  logic [COORD_W:0]     diff;
  logic                 ge;
  logic [COORD_W-1:0]   rem_nxt;

  // Quotient fits QUO_W bits, so the upper numerator bits already sit below the divisor.
  assign trial   = {rem_r, lo_r[QUO_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = (trial >= {1'b0, den_r});
  assign rem_nxt = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= {1'b0, num[NUM_W-1:QUO_W]};
        lo_r   <= num[QUO_W-1:0];
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        lo_r  <= {lo_r[QUO_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = lo_r;

endmodule

`default_nettype wire

// ===== rtl/dda_front.sv =====
// Front end: takes line requests, works out steps and fixed-point increments.
`default_nettype none

module dda_front import dda_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  dda_in_if.sink    in_line,
  output logic      cmd_valid,
  input  wire logic cmd_ready,
  output dda_cmd_t  cmd
);

  typedef enum logic [2:0] {F_IDLE, F_CLASS, F_START, F_WAIT, F_PUSH} fstate_t;

  fstate_t                   state_r;
  logic signed [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COLOR_W-1:0]        color_r;
  logic [COORD_W-1:0]        absx_r, absy_r, steps_r;
  logic                      negx_r, negy_r, cut_r;
  logic [CNT_W-1:0]          last_r;
  logic                      div_start_r;

  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          negdx, negdy;
  logic [COORD_W-1:0]        absx, absy, steps;
  logic [NUM_W-1:0]          num_x, num_y;
  logic                      done_x, done_y;
  logic [QUO_W-1:0]          quo_x, quo_y;
  logic [INC_W-1:0]          mag_x, mag_y;

  assign dx    = {ex_r[COORD_W-1], ex_r} - {sx_r[COORD_W-1], sx_r};
  assign dy    = {ey_r[COORD_W-1], ey_r} - {sy_r[COORD_W-1], sy_r};
  assign negdx = -dx;
  assign negdy = -dy;
  assign absx  = dx[COORD_W] ? negdx[COORD_W-1:0] : dx[COORD_W-1:0];
  assign absy  = dy[COORD_W] ? negdy[COORD_W-1:0] : dy[COORD_W-1:0];
  assign steps = (absx > absy) ? absx : absy;

  // Add half the divisor so the quotient rounds to nearest, ties away from zero.
  assign num_x = {absx_r, {FRAC_BITS{1'b0}}} + NUM_W'(steps_r >> 1);
  assign num_y = {absy_r, {FRAC_BITS{1'b0}}} + NUM_W'(steps_r >> 1);

  dda_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (num_x),
    .den   (steps_r),
    .done  (done_x),
    .quo   (quo_x)
  );

  dda_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (num_y),
    .den   (steps_r),
    .done  (done_y),
    .quo   (quo_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      case (state_r)
        F_IDLE: begin
          if (in_line.valid) begin
            sx_r    <= in_line.start_x;
            sy_r    <= in_line.start_y;
            ex_r    <= in_line.end_x;
            ey_r    <= in_line.end_y;
            color_r <= in_line.line_color;
            state_r <= F_CLASS;
          end
        end
        F_CLASS: begin
          absx_r  <= absx;
          absy_r  <= absy;
          negx_r  <= dx[COORD_W];
          negy_r  <= dy[COORD_W];
          steps_r <= steps;
          cut_r   <= (steps > COORD_W'(MAX_STEPS));
          last_r  <= (steps > COORD_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : steps[CNT_W-1:0];
          state_r <= F_START;
        end
        F_START: begin
          // Skip the divide for a zero-length line.
          if (steps_r == '0) begin
            state_r <= F_PUSH;
          end else begin
            div_start_r <= 1'b1;
            state_r     <= F_WAIT;
          end
        end
        F_WAIT: begin
          if (done_x && done_y) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (cmd_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign mag_x = (steps_r == '0) ? '0 : {1'b0, quo_x};
  assign mag_y = (steps_r == '0) ? '0 : {1'b0, quo_y};

  assign in_line.ready = (state_r == F_IDLE);
  assign cmd_valid     = (state_r == F_PUSH);

  always_comb begin
    cmd.start_x  = sx_r;
    cmd.start_y  = sy_r;
    cmd.inc_x    = negx_r ? -mag_x : mag_x;
    cmd.inc_y    = negy_r ? -mag_y : mag_y;
    cmd.last_idx = last_r;
    cmd.cut      = cut_r;
    cmd.color    = color_r;
  end

endmodule

`default_nettype wire

// ===== rtl/dda_queue.sv =====
// Short command queue between front and back ends.
`default_nettype none

module dda_queue import dda_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire dda_cmd_t push_cmd,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output dda_cmd_t      pop_cmd
);

  dda_cmd_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dda_back.sv =====
// Back end: steps the fixed-point position and emits one pixel per cycle while the pixel output is not stalled.
`default_nettype none

module dda_back import dda_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  output logic          cmd_ready,
  input  wire dda_cmd_t cmd,
  dda_out_if.source     out_pixel
);

  logic                      busy_r;
  logic signed [ACC_W-1:0]   acc_x_r, acc_y_r, inc_x_r, inc_y_r;
  logic [CNT_W-1:0]          left_r;
  logic                      cut_r;
  logic [COLOR_W-1:0]        color_r;

  logic                      ov_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic [COLOR_W-1:0]        pc_r;
  logic                      last_r, trunc_r;

  logic                      emit;
  logic                      final_px;

  // Integer part of a fixed-point value, rounded toward zero.
  function automatic logic [COORD_W-1:0] to_int(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-FRAC_BITS-1:0] ip;
    ip = a[ACC_W-1:FRAC_BITS];
    if (a[ACC_W-1] && (|a[FRAC_BITS-1:0])) begin
      ip = ip + 1'b1;
    end
    return ip[COORD_W-1:0];
  endfunction

  assign cmd_ready = !busy_r;
  assign emit      = busy_r && (!ov_r || out_pixel.ready);
  assign final_px  = (left_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (cmd_valid && !busy_r) begin
        busy_r  <= 1'b1;
        acc_x_r <= {{2{cmd.start_x[COORD_W-1]}}, cmd.start_x, {FRAC_BITS{1'b0}}};
        acc_y_r <= {{2{cmd.start_y[COORD_W-1]}}, cmd.start_y, {FRAC_BITS{1'b0}}};
        inc_x_r <= {{(ACC_W-INC_W){cmd.inc_x[INC_W-1]}}, cmd.inc_x};
        inc_y_r <= {{(ACC_W-INC_W){cmd.inc_y[INC_W-1]}}, cmd.inc_y};
        left_r  <= cmd.last_idx;
        cut_r   <= cmd.cut;
        color_r <= cmd.color;
      end
      if (emit) begin
        ov_r    <= 1'b1;
        px_r    <= to_int(acc_x_r);
        py_r    <= to_int(acc_y_r);
        pc_r    <= color_r;
        last_r  <= final_px;
        trunc_r <= final_px && cut_r;
        acc_x_r <= acc_x_r + inc_x_r;
        acc_y_r <= acc_y_r + inc_y_r;
        if (final_px) begin
          busy_r <= 1'b0;
        end else begin
          left_r <= left_r - 1'b1;
        end
      end else if (out_pixel.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_pixel.valid         = ov_r;
  assign out_pixel.pixel_x       = px_r;
  assign out_pixel.pixel_y       = py_r;
  assign out_pixel.pixel_color   = pc_r;
  assign out_pixel.last_pixel    = last_r;
  assign out_pixel.was_truncated = trunc_r;

endmodule

`default_nettype wire

// ===== bench/dda_line_rasterizer_tb.sv =====
// Self-checking bench for the DDA line rasteriser: directed table, random lines, pixel check.
`timescale 1ns / 1ps

module dda_line_rasterizer_tb;
  import dda_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int N_RANDOM     = 358;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AFTER   = 1500;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0]        colour_t;

  typedef struct packed {
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
    colour_t line_color;
  } line_req_t;

  typedef struct packed {
    coord_t  pixel_x;
    coord_t  pixel_y;
    colour_t pixel_color;
    logic    last_pixel;
    logic    was_truncated;
  } pixel_t;

  // typed rows carry the single pixel of a zero-length line
  typedef struct {
    int          sx;
    int          sy;
    int          ex;
    int          ey;
    int unsigned colour;
    bit          typed;
    int          exp_x;
    int          exp_y;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  dda_in_if  in_line ();
  dda_out_if out_pixel ();

  dda_line_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_line   (in_line),
    .out_pixel (out_pixel)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state, mirrors the block's registers
  longint  fx_pos_x;
  longint  fx_pos_y;
  longint  fx_inc_x;
  longint  fx_inc_y;
  longint  owed_pixels;
  colour_t held_colour;

  pixel_t   expected_pixels [$];
  dir_row_t directed_rows [$];

  int lines_accepted = 0;
  int pixels_seen    = 0;
  int cut_lines      = 0;
  int zero_lines     = 0;
  int mismatches     = 0;

  // d * 2^FRAC_BITS / steps, rounded to nearest, ties away from zero
  function automatic longint fix_step(longint d, longint steps);
    longint mag;
    if (steps <= 0) return 0;
    mag = (((d < 0) ? -d : d) * (longint'(1) << FRAC_BITS) + steps / 2) / steps;
    return (d < 0) ? -mag : mag;
  endfunction

  // drop the fraction, truncating toward zero
  function automatic coord_t fix_to_coord(longint a);
    longint whole;
    whole = (a >= 0) ? (a >>> FRAC_BITS) : -((-a) >>> FRAC_BITS);
    return coord_t'(whole);
  endfunction

  function automatic void predict_line(line_req_t r);
    longint dx, dy, adx, ady, span, count;
    bit     cut;
    pixel_t p;
    dx    = longint'(r.end_x) - longint'(r.start_x);
    dy    = longint'(r.end_y) - longint'(r.start_y);
    adx   = (dx < 0) ? -dx : dx;
    ady   = (dy < 0) ? -dy : dy;
    span  = (adx > ady) ? adx : ady;
    cut   = (span > MAX_STEPS);
    count = (cut ? longint'(MAX_STEPS) : span) + 1;
    held_colour = r.line_color;
    fx_inc_x    = fix_step(dx, span);
    fx_inc_y    = fix_step(dy, span);
    fx_pos_x    = longint'(r.start_x) * (longint'(1) << FRAC_BITS);
    fx_pos_y    = longint'(r.start_y) * (longint'(1) << FRAC_BITS);
    owed_pixels = count;
    for (longint i = 0; i < count; i++) begin
      if (i > 0) begin
        fx_pos_x += fx_inc_x;
        fx_pos_y += fx_inc_y;
      end
      p.pixel_x       = fix_to_coord(fx_pos_x);
      p.pixel_y       = fix_to_coord(fx_pos_y);
      p.pixel_color   = held_colour;
      p.last_pixel    = (i == count - 1);
      p.was_truncated = p.last_pixel && cut;
      expected_pixels.push_back(p);
      owed_pixels--;
    end
    if (cut) cut_lines++;
    if (span == 0) zero_lines++;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 95) return $urandom_range(5, 30);
    return $urandom_range(40, 120);
  endfunction

  function automatic line_req_t random_line();
    line_req_t r;
    int sx, sy, ex, ey, dx, dy, len, minor, roll;
    roll = $urandom_range(0, 99);
    sx   = int'($urandom_range(0, 4095)) - 2048;
    sy   = int'($urandom_range(0, 4095)) - 2048;
    dx   = 0;
    dy   = 0;
    if (roll < 8) begin
      dx = 0;
      dy = 0;
    end else if (roll < 63) begin
      dx = int'($urandom_range(0, 24)) - 12;
      dy = int'($urandom_range(0, 24)) - 12;
    end else if (roll < 83) begin
      // around the step limit
      len   = $urandom_range(60, 66);
      minor = int'($urandom_range(0, 2 * len)) - len;
      if ($urandom_range(0, 1) == 1) begin
        dx = len;
        dy = minor;
      end else begin
        dx = minor;
        dy = len;
      end
      if ($urandom_range(0, 1) == 1) begin
        dx = -dx;
        dy = -dy;
      end
    end else if (roll < 88) begin
      // axis-aligned and 45-degree lines
      len = $urandom_range(1, 70);
      dx  = ($urandom_range(0, 1) == 1) ? len : -len;
      case ($urandom_range(0, 2))
        0:       dy = 0;
        1:       dy = len;
        default: dy = -len;
      endcase
      if ($urandom_range(0, 1) == 1) begin
        minor = dx;
        dx    = dy;
        dy    = minor;
      end
    end
    if (roll < 88) begin
      ex = sx + dx;
      if (ex > 2047 || ex < -2048) ex = sx - dx;
      ey = sy + dy;
      if (ey > 2047 || ey < -2048) ey = sy - dy;
    end else begin
      ex = int'($urandom_range(0, 4095)) - 2048;
      ey = int'($urandom_range(0, 4095)) - 2048;
    end
    r.start_x    = coord_t'(sx);
    r.start_y    = coord_t'(sy);
    r.end_x      = coord_t'(ex);
    r.end_y      = coord_t'(ey);
    r.line_color = colour_t'($urandom);
    return r;
  endfunction

  // offer one line, record what it must produce, then idle as asked
  task automatic issue_line(line_req_t r, bit typed, int tx, int ty, bit steady);
    pixel_t p;
    int     pause;
    in_line.valid      <= 1'b1;
    in_line.start_x    <= r.start_x;
    in_line.start_y    <= r.start_y;
    in_line.end_x      <= r.end_x;
    in_line.end_y      <= r.end_y;
    in_line.line_color <= r.line_color;
    @(posedge clk);
    while (!in_line.ready) @(posedge clk);
    lines_accepted++;
    if (typed) begin
      p.pixel_x       = coord_t'(tx);
      p.pixel_y       = coord_t'(ty);
      p.pixel_color   = r.line_color;
      p.last_pixel    = 1'b1;
      p.was_truncated = 1'b0;
      expected_pixels.push_back(p);
      zero_lines++;
    end else begin
      predict_line(r);
    end
    pause = steady ? 0 : pick_gap();
    if (pause > 0) begin
      in_line.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endtask

  // stimulus
  initial begin : line_source
    line_req_t req;
    bit        steady;
    rst_n              = 1'b0;
    in_line.valid      = 1'b0;
    in_line.start_x    = '0;
    in_line.start_y    = '0;
    in_line.end_x      = '0;
    in_line.end_y      = '0;
    in_line.line_color = '0;
    steady             = 1'b0;

    //                          sx     sy     ex     ey     colour   typed  ex_x   ex_y
    directed_rows.push_back(dir_row_t'{    0,     0,     0,     0, 'h000000, 1,     0,     0});
    directed_rows.push_back(dir_row_t'{-2048, -2048, -2048, -2048, 'hFFFFFF, 1, -2048, -2048});
    directed_rows.push_back(dir_row_t'{ 2047,  2047,  2047,  2047, 'h5A5A5A, 1,  2047,  2047});
    directed_rows.push_back(dir_row_t'{-2048,  2047, -2048,  2047, 'hA5A5A5, 1, -2048,  2047});
    directed_rows.push_back(dir_row_t'{ 2047, -2048,  2047, -2048, 'h123456, 1,  2047, -2048});
    directed_rows.push_back(dir_row_t'{    0,     0,     3,     0, 'h0000FF, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{    0,     0,     0,    -5, 'h00FF00, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{   10,    10,   -10,   -10, 'hFF0000, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{    0,     0,     7,    63, 'h800001, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{    0,     0,    64,     0, 'h7FFFFE, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{    0,     0,    -1,    -3, 'h0F0F0F, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{    0,     0,     2,    -7, 'hF0F0F0, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{   -1,    -1,     1,     1, 'hC3C3C3, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{    5,    -3,   -58,    17, 'h3C3C3C, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{-2048, -2048,  2047,  2047, 'hFFFFFF, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{ 2047, -2048, -2048,  2047, 'h000001, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{ 2047,  2047, -2048, -2048, 'h800000, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{ 2040, -2040,  2047, -2047, 'hABCDEF, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{-2048,     0, -1985,    63, 'h654321, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{    0,  2047,   -62,  2047, 'h13579B, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{  100,   100,    37,  -100, 'h2468AC, 0, 0, 0});
    directed_rows.push_back(dir_row_t'{   -5,     7,    -4,    70, 'hFEDCBA, 0, 0, 0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      req.start_x    = coord_t'(directed_rows[k].sx);
      req.start_y    = coord_t'(directed_rows[k].sy);
      req.end_x      = coord_t'(directed_rows[k].ex);
      req.end_y      = coord_t'(directed_rows[k].ey);
      req.line_color = colour_t'(directed_rows[k].colour);
      issue_line(req, directed_rows[k].typed, directed_rows[k].exp_x,
                 directed_rows[k].exp_y, 1'b0);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // switch between gap-free stretches and gappy ones
      if (n % 25 == 0) steady = ($urandom_range(0, 3) == 0);
      req = random_line();
      issue_line(req, 1'b0, 0, 0, steady);
    end
    in_line.valid <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d lines (%0d zero-length, %0d cut at the step limit), %0d pixels,",
             lines_accepted, zero_lines, cut_lines, pixels_seen);
    $display("with random stalls on both sides and one long hold-off of the pixel stream.");
    if (mismatches == 0) begin
      $display("** dda_line_rasterizer: PASSED **");
    end else begin
      $display("%0d pixel errors", mismatches);
      $display("** dda_line_rasterizer: FAILED **");
    end
    $finish;
  end

  // pixel receiver: random ready, one long hold-off to fill the block
  initial begin : pixel_sink
    int roll, run_len, stall_len;
    bit pressure_done;
    out_pixel.ready = 1'b0;
    pressure_done   = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      roll      = $urandom_range(0, 99);
      run_len   = (roll < 75) ? $urandom_range(1, 8) : $urandom_range(20, 200);
      roll      = $urandom_range(0, 99);
      stall_len = (roll < 80) ? $urandom_range(1, 3) :
                  (roll < 95) ? $urandom_range(4, 15) : $urandom_range(30, 80);
      if (!pressure_done && pixels_seen >= HOLD_AFTER) begin
        stall_len     = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      out_pixel.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      out_pixel.ready <= 1'b0;
      repeat (stall_len) @(posedge clk);
    end
  end

  // compare each pixel transaction with the oldest expectation
  always @(posedge clk) begin : pixel_check
    pixel_t got, want;
    if (rst_n && out_pixel.valid && out_pixel.ready) begin
      pixels_seen++;
      got.pixel_x       = out_pixel.pixel_x;
      got.pixel_y       = out_pixel.pixel_y;
      got.pixel_color   = out_pixel.pixel_color;
      got.last_pixel    = out_pixel.last_pixel;
      got.was_truncated = out_pixel.was_truncated;
      if (expected_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel x=%0d y=%0d colour=%06h last=%0b trunc=%0b",
                             got.pixel_x, got.pixel_y, got.pixel_color, got.last_pixel,
                             got.was_truncated));
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
            got.pixel_color !== want.pixel_color || got.last_pixel !== want.last_pixel ||
            got.was_truncated !== want.was_truncated) begin
          flag_error($sformatf({"pixel mismatch: want x=%0d y=%0d colour=%06h last=%0b ",
                                "trunc=%0b, got x=%0d y=%0d colour=%06h last=%0b trunc=%0b"},
                               want.pixel_x, want.pixel_y, want.pixel_color, want.last_pixel,
                               want.was_truncated, got.pixel_x, got.pixel_y,
                               got.pixel_color, got.last_pixel, got.was_truncated));
        end
      end
    end
  end

  // end the run if no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_line.valid && in_line.ready) || (out_pixel.valid && out_pixel.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles, %0d pixels still expected",
             STALL_LIMIT, expected_pixels.size());
    $display("** dda_line_rasterizer: FAILED **");
    $finish;
  end

endmodule
